// ===== design/aminv_pkg.sv =====
// Shared types and constants for the affine matrix inverse block.
package aminv_pkg;

  localparam int unsigned W         = 32;
  localparam int unsigned NLANE     = 6;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 3;
  localparam int unsigned FRONT_LAT = 3;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + DIV_LAT + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

  // One division job: round((num << sh) / den), sh is 16 or 32.
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic        sh16;
  } aminv_lane_t;

  typedef struct packed {
    logic [NLANE-1:0][W-1:0] pass;
    logic                    singular;
  } aminv_side_t;

endpackage

// ===== design/aminv_front.sv =====
// Front end: products, determinant and cofactors, and division job setup.
module aminv_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic [aminv_pkg::W-1:0]                 xx,
  input  logic [aminv_pkg::W-1:0]                 yx,
  input  logic [aminv_pkg::W-1:0]                 xy,
  input  logic [aminv_pkg::W-1:0]                 yy,
  input  logic [aminv_pkg::W-1:0]                 tx,
  input  logic [aminv_pkg::W-1:0]                 ty,
  output logic                                    out_valid,
  output aminv_pkg::aminv_lane_t [aminv_pkg::NLANE-1:0] lanes,
  output aminv_pkg::aminv_side_t                  side
);

  logic v1, v2;
  logic signed [31:0] r_xx, r_yx, r_xy, r_yy, r_tx, r_ty;
  logic [5:0][31:0] m_in;
  logic signed [63:0] p_xxyy, p_yxxy, p_xyty, p_yytx, p_yxtx, p_xxty;
  logic [63:0] det, ctx, cty;
  logic fast;
  aminv_pkg::aminv_lane_t [aminv_pkg::NLANE-1:0] lanes_next;
  aminv_pkg::aminv_side_t side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // register the word, then the six products
  always_ff @(posedge clk) begin
    r_xx <= xx;
    r_yx <= yx;
    r_xy <= xy;
    r_yy <= yy;
    r_tx <= tx;
    r_ty <= ty;
    p_xxyy <= r_xx * r_yy;
    p_yxxy <= r_yx * r_xy;
    p_xyty <= r_xy * r_ty;
    p_yytx <= r_yy * r_tx;
    p_yxtx <= r_yx * r_tx;
    p_xxty <= r_xx * r_ty;
    m_in <= {r_ty, r_tx, r_yy, r_xy, r_yx, r_xx};
  end

  always_comb begin
    det  = 64'(p_xxyy) - 64'(p_yxxy);
    ctx  = 64'(p_xyty) - 64'(p_yytx);
    cty  = 64'(p_yxtx) - 64'(p_xxty);
    fast = (m_in[1] == '0) && (m_in[2] == '0);
    side_next.pass = m_in;
    if (fast) begin
      side_next.singular = (m_in[0] == '0) || (m_in[3] == '0);
      lanes_next[0] = '{num: 64'd1, den: {{32{m_in[0][31]}}, m_in[0]}, sh16: 1'b0};
      lanes_next[1] = '{num: 64'd0, den: 64'd1, sh16: 1'b0};
      lanes_next[2] = '{num: 64'd0, den: 64'd1, sh16: 1'b0};
      lanes_next[3] = '{num: 64'd1, den: {{32{m_in[3][31]}}, m_in[3]}, sh16: 1'b0};
      lanes_next[4] = '{num: 64'd0 - {{32{m_in[4][31]}}, m_in[4]},
                        den: {{32{m_in[0][31]}}, m_in[0]}, sh16: 1'b1};
      lanes_next[5] = '{num: 64'd0 - {{32{m_in[5][31]}}, m_in[5]},
                        den: {{32{m_in[3][31]}}, m_in[3]}, sh16: 1'b1};
    end else begin
      side_next.singular = (det == '0);
      lanes_next[0] = '{num: {{32{m_in[3][31]}}, m_in[3]}, den: det, sh16: 1'b0};
      lanes_next[1] = '{num: 64'd0 - {{32{m_in[1][31]}}, m_in[1]}, den: det, sh16: 1'b0};
      lanes_next[2] = '{num: 64'd0 - {{32{m_in[2][31]}}, m_in[2]}, den: det, sh16: 1'b0};
      lanes_next[3] = '{num: {{32{m_in[0][31]}}, m_in[0]}, den: det, sh16: 1'b0};
      lanes_next[4] = '{num: ctx, den: det, sh16: 1'b1};
      lanes_next[5] = '{num: cty, den: det, sh16: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    lanes <= lanes_next;
    side  <= side_next;
  end

endmodule

// ===== design/aminv_div.sv =====
// Pipelined restoring divider lane: rounded, saturated 32-bit quotient.
module aminv_div (
  input  logic                          clk,
  input  aminv_pkg::aminv_lane_t        job,
  output logic [aminv_pkg::W-1:0]       res,
  output logic                          sat
);

  localparam int unsigned N = aminv_pkg::DIV_STEPS;

  logic [63:0] nm, dm_a;
  logic        neg_a, sh16_a;
  logic [95:0] mag;

  logic [63:0]   rem [0:N];
  logic [N-1:0]  low [0:N];
  logic [N-1:0]  q   [0:N];
  logic [63:0]   dm  [0:N];
  logic          neg [0:N];
  logic          ovf [0:N];

  logic        rnd;
  logic [32:0] qr, lim;
  logic        sat_next;
  logic [31:0] res_next;

  // take magnitudes
  always_ff @(posedge clk) begin
    nm     <= job.num[63] ? 64'd0 - job.num : job.num;
    dm_a   <= job.den[63] ? 64'd0 - job.den : job.den;
    neg_a  <= job.num[63] ^ job.den[63];
    sh16_a <= job.sh16;
  end

  assign mag = sh16_a ? {16'd0, nm, 16'd0} : {nm, 32'd0};

  // flag a quotient of 2^32 or more for saturation
  always_ff @(posedge clk) begin
    rem[0] <= mag[95:32];
    low[0] <= mag[31:0];
    q[0]   <= '0;
    dm[0]  <= dm_a;
    neg[0] <= neg_a;
    ovf[0] <= mag >= {dm_a, 32'd0};
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [64:0] t;
    logic        ge;
    assign t  = {rem[i], low[i][N-1]};
    assign ge = t >= {1'b0, dm[i]};
    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? 64'(t - {1'b0, dm[i]}) : t[63:0];
      low[i+1] <= {low[i][N-2:0], 1'b0};
      q[i+1]   <= {q[i][N-2:0], ge};
      dm[i+1]  <= dm[i];
      neg[i+1] <= neg[i];
      ovf[i+1] <= ovf[i];
    end
  end

  always_comb begin
    rnd      = {rem[N], 1'b0} >= {1'b0, dm[N]};
    qr       = {1'b0, q[N]} + {32'd0, rnd};
    lim      = neg[N] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    sat_next = ovf[N] || (qr > lim);
    if (sat_next) begin
      res_next = neg[N] ? aminv_pkg::SAT_NEG : aminv_pkg::SAT_POS;
    end else begin
      res_next = neg[N] ? 32'd0 - qr[31:0] : qr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    sat <= sat_next;
  end

endmodule

// ===== design/affine_matrix_invert.sv =====
// Top level of the 2x3 affine matrix inverse pipeline.
// Inverts one signed Q16.16 affine matrix per word; a new word may be started
// in every clock cycle and busy is high only during reset. Each result passes
// through three front stages (register, six 32x32 multipliers, determinant and
// setup), the six divider lanes (magnitude, overflow check, one quotient bit
// per stage for 32 stages, round and saturate), and one output register. done
// marks each result for exactly one cycle and results cannot be held off, so
// take them when done is high. status reads success, singular (input passed
// through unchanged) or success with at least one output clamped to the
// 32-bit range.
module affine_matrix_invert (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_xx,
  input  logic [31:0] in_yx,
  input  logic [31:0] in_xy,
  input  logic [31:0] in_yy,
  input  logic [31:0] in_tx,
  input  logic [31:0] in_ty,
  output logic        done,
  output logic [31:0] out_xx,
  output logic [31:0] out_yx,
  output logic [31:0] out_xy,
  output logic [31:0] out_yy,
  output logic [31:0] out_tx,
  output logic [31:0] out_ty,
  output logic [1:0]  status
);

  localparam int unsigned L = aminv_pkg::DIV_LAT;

  logic                   front_valid;
  aminv_pkg::aminv_lane_t [aminv_pkg::NLANE-1:0] lanes;
  aminv_pkg::aminv_side_t side;

  logic [31:0]            q   [0:aminv_pkg::NLANE-1];
  logic [aminv_pkg::NLANE-1:0] lane_sat;

  aminv_pkg::aminv_side_t side_d [0:L-1];
  logic [L-1:0]           valid_d;

  logic [5:0][31:0]       res_next;
  logic [1:0]             status_next;

  // hold off new words only while in reset
  assign busy = rst;

  aminv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .xx        (in_xx),
    .yx        (in_yx),
    .xy        (in_xy),
    .yy        (in_yy),
    .tx        (in_tx),
    .ty        (in_ty),
    .out_valid (front_valid),
    .lanes     (lanes),
    .side      (side)
  );

  for (genvar k = 0; k < aminv_pkg::NLANE; k++) begin : g_lane
    aminv_div u_div (
      .clk (clk),
      .job (lanes[k]),
      .res (q[k]),
      .sat (lane_sat[k])
    );
  end

  // advance valid bits and the pass-through copy alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= '0;
    end else begin
      valid_d <= {valid_d[L-2:0], front_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_d[0] <= side;
    for (int i = 1; i < L; i++) begin
      side_d[i] <= side_d[i-1];
    end
  end

  // pick the pass-through input on a singular matrix, else the quotients
  always_comb begin
    if (side_d[L-1].singular) begin
      res_next    = side_d[L-1].pass;
      status_next = aminv_pkg::ST_SINGULAR;
    end else begin
      res_next    = {q[5], q[4], q[3], q[2], q[1], q[0]};
      status_next = (lane_sat != '0) ? aminv_pkg::ST_SAT : aminv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_d[L-1];
    end
  end

  always_ff @(posedge clk) begin
    out_xx <= res_next[0];
    out_yx <= res_next[1];
    out_xy <= res_next[2];
    out_yy <= res_next[3];
    out_tx <= res_next[4];
    out_ty <= res_next[5];
    status <= status_next;
  end

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##39 done)
    else $error("accepted word produced no result after fixed latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 39))
    else $error("result with no matching accepted word");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    done |-> (status == aminv_pkg::ST_OK || status == aminv_pkg::ST_SINGULAR ||
              status == aminv_pkg::ST_SAT))
    else $error("undefined status code");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the affine matrix inverse pipeline.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] xx, yx, xy, yy, tx, ty;
  } matrix_t;

  typedef struct packed {
    logic [31:0] xx, yx, xy, yy, tx, ty;
    logic [1:0]  st;
  } inverse_t;

  // One directed row: the matrix, and the inverse when it can be typed in directly.
  typedef struct packed {
    matrix_t  m;
    logic     typed;
    inverse_t inv;
  } row_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam int NRAND = 1430;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] in_xx, in_yx, in_xy, in_yy, in_tx, in_ty;
  logic        done;
  logic [31:0] out_xx, out_yx, out_xy, out_yy, out_tx, out_ty;
  logic [1:0]  status;

  inverse_t pending_inverses[$];
  int       mismatches;
  bit       quiet_tail;

  affine_matrix_invert dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("affine_matrix_invert verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Rounded (ties away from zero), saturated quotient of (num << sh) / den.
  function automatic logic [31:0] round_div(input logic signed [63:0] num, input int sh,
                                            input logic signed [63:0] den,
                                            inout bit clamped);
    logic [127:0] nm, dm, q, r;
    bit neg;
    nm = num[63] ? 128'(-num) : 128'(num);
    dm = den[63] ? 128'(-den) : 128'(den);
    nm = nm << sh;
    q = nm / dm;
    r = nm % dm;
    if (r >= dm - r) q++;
    neg = num[63] != den[63];
    if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
      clamped = 1'b1;
      return neg ? MINN : MAXP;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic logic [31:0] negate_sat(input logic [31:0] v, inout bit clamped);
    if (v == MINN) begin
      clamped = 1'b1;
      return MAXP;
    end
    return -v;
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t m);
    logic signed [63:0] xx, yx, xy, yy, tx, ty, det, ctx, cty;
    inverse_t o;
    bit clamped, singular;
    xx = 64'(signed'(m.xx)); yx = 64'(signed'(m.yx)); xy = 64'(signed'(m.xy));
    yy = 64'(signed'(m.yy)); tx = 64'(signed'(m.tx)); ty = 64'(signed'(m.ty));
    clamped = 1'b0;
    singular = 1'b0;
    o = '0;
    if (yx == 0 && xy == 0) begin
      // diagonal only: invert each scale term independently
      if (xx == 0 || yy == 0) singular = 1'b1;
      else begin
        if (m.xx == ONE) begin
          o.xx = ONE;
          o.tx = negate_sat(m.tx, clamped);
        end else begin
          o.xx = round_div(64'sd1, 32, xx, clamped);
          o.tx = round_div(-tx, 16, xx, clamped);
        end
        if (m.yy == ONE) begin
          o.yy = ONE;
          o.ty = negate_sat(m.ty, clamped);
        end else begin
          o.yy = round_div(64'sd1, 32, yy, clamped);
          o.ty = round_div(-ty, 16, yy, clamped);
        end
      end
    end else begin
      det = xx * yy - yx * xy;
      if (det == 0) singular = 1'b1;
      else begin
        ctx = xy * ty - yy * tx;
        cty = yx * tx - xx * ty;
        o.xx = round_div(yy, 32, det, clamped);
        o.yx = round_div(-yx, 32, det, clamped);
        o.xy = round_div(-xy, 32, det, clamped);
        o.yy = round_div(xx, 32, det, clamped);
        o.tx = round_div(ctx, 16, det, clamped);
        o.ty = round_div(cty, 16, det, clamped);
      end
    end
    if (singular) begin
      o = {m, aminv_pkg::ST_SINGULAR};
    end else begin
      o.st = clamped ? aminv_pkg::ST_SAT : aminv_pkg::ST_OK;
    end
    return o;
  endfunction

  // Check every result word against the oldest pending inverse.
  always @(posedge clk) begin
    inverse_t want;
    if (!rst && done) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("unexpected word", out_xx, '0);
      end else begin
        want = pending_inverses.pop_front();
        if (out_xx !== want.xx) report_mismatch("out_xx", out_xx, want.xx);
        if (out_yx !== want.yx) report_mismatch("out_yx", out_yx, want.yx);
        if (out_xy !== want.xy) report_mismatch("out_xy", out_xy, want.xy);
        if (out_yy !== want.yy) report_mismatch("out_yy", out_yy, want.yy);
        if (out_tx !== want.tx) report_mismatch("out_tx", out_tx, want.tx);
        if (out_ty !== want.ty) report_mismatch("out_ty", out_ty, want.ty);
        if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE;
      2: return MAXP;
      3: return MINN;
      4: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      5: return 32'($signed($urandom_range(0, 2000)) - 1000);
      6: return 32'h0000_0001 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    m.xx = pick_value(); m.yy = pick_value();
    m.tx = pick_value(); m.ty = pick_value();
    case ($urandom_range(0, 5))
      0, 1: begin
        m.yx = '0; m.xy = '0;       // diagonal fast path
      end
      2: begin
        // force a zero determinant: xx*yy == yx*xy
        m.yx = m.xx; m.xy = m.yy;
      end
      default: begin
        m.yx = pick_value(); m.xy = pick_value();
      end
    endcase
    return m;
  endfunction

  // Present one word and hold it until it is taken; idle in short bursts.
  task automatic send_word(input matrix_t m, input logic typed, input inverse_t inv);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {in_xx, in_yx, in_xy, in_yy, in_tx, in_ty} <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_inverses.push_back(typed ? inv : invert_matrix(m));
  endtask

  row_t directed_rows[$];

  initial begin
    matrix_t m;
    mismatches = 0;
    quiet_tail = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    {in_xx, in_yx, in_xy, in_yy, in_tx, in_ty} = '0;

    // identity, singular cases, extremes, shears
    directed_rows.push_back('{'{ONE, 0, 0, ONE, 0, 0}, 1'b1,
                              '{ONE, 0, 0, ONE, 0, 0, aminv_pkg::ST_OK}});
    directed_rows.push_back('{'{0, 0, 0, ONE, 5, 6}, 1'b1,
                              '{0, 0, 0, ONE, 5, 6, aminv_pkg::ST_SINGULAR}});
    directed_rows.push_back('{'{ONE, 0, 0, 0, 7, MINN}, 1'b1,
                              '{ONE, 0, 0, 0, 7, MINN, aminv_pkg::ST_SINGULAR}});
    directed_rows.push_back('{'{ONE, ONE, ONE, ONE, MAXP, 3}, 1'b1,
                              '{ONE, ONE, ONE, ONE, MAXP, 3, aminv_pkg::ST_SINGULAR}});
    directed_rows.push_back('{'{ONE, 0, 0, ONE, MINN, MAXP}, 1'b1,
                              '{ONE, 0, 0, ONE, MAXP, MINN + 1, aminv_pkg::ST_SAT}});
    directed_rows.push_back('{'{ONE, 0, 0, ONE, 32'hFFFF_FFFF, 1}, 1'b1,
                              '{ONE, 0, 0, ONE, 1, 32'hFFFF_FFFF, aminv_pkg::ST_OK}});
    directed_rows.push_back('{'{32'h2_0000, 0, 0, 32'hFFFE_0000, ONE, ONE}, 0, '0});
    directed_rows.push_back('{'{1, 0, 0, 32'hFFFF_FFFF, 0, 0}, 0, '0});
    directed_rows.push_back('{'{MAXP, 0, 0, MINN, MAXP, MINN}, 0, '0});
    directed_rows.push_back('{'{MINN, 0, 0, MINN, MINN, MINN}, 0, '0});
    directed_rows.push_back('{'{ONE, ONE, 0, ONE, 0, 0}, 0, '0});
    directed_rows.push_back('{'{0, ONE, ONE, 0, ONE, ONE}, 0, '0});
    directed_rows.push_back('{'{MAXP, MINN, MINN, MAXP, MAXP, MINN}, 0, '0});
    directed_rows.push_back('{'{MINN, MAXP, MAXP, MINN, MINN, MAXP}, 0, '0});
    directed_rows.push_back('{'{1, 1, 0, 1, MAXP, MAXP}, 0, '0});
    directed_rows.push_back('{'{32'h3_0000, 32'h1_8000, 32'hFFFF_8000, 32'h2_0000,
                                32'h10_0000, 32'hFFF0_0000}, 0, '0});
    directed_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, '0});
    directed_rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].m, directed_rows[i].typed, directed_rows[i].inv);

    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND - 200) quiet_tail = 1'b1;   // back-to-back words at the end
      m = random_matrix();
      send_word(m, 1'b0, '0);
    end
    start <= 1'b0;

    // drain the pipeline, bounded
    for (int w = 0; w < 20 * aminv_pkg::TOTAL_LAT && pending_inverses.size() != 0; w++)
      @(posedge clk);
    repeat (aminv_pkg::TOTAL_LAT + 5) @(posedge clk);

    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("affine_matrix_invert verification clean");
    end else begin
      $display("affine_matrix_invert verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/aminv_pkg.sv
design/aminv_front.sv
design/aminv_div.sv
design/affine_matrix_invert.sv
tb/sv/testbench.sv
